### design/smt_pkg.sv
// Shared types, codes and field widths of the sorted marker table.
`timescale 1ns / 1ps
`default_nettype none

package smt_pkg;

	localparam int MAX_MARKERS_DEF   = 64;
	localparam int POSITION_BITS_DEF = 28;

	localparam int OP_W     = 3;
	localparam int POS_W    = 28;
	localparam int IDX_W    = 8;
	localparam int SLOT_W   = 6;
	localparam int COUNT_W  = 7;
	localparam int LEN_W    = 28;
	localparam int STATUS_W = 2;

	localparam logic [LEN_W-1:0] TOTAL_LEN_RST = 28'hFFFFFFF;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 3'd0,
		OP_ADD     = 3'd1,
		OP_SET     = 3'd2,
		OP_SHIFT   = 3'd3,
		OP_CLOSEST = 3'd4,
		OP_DELETE  = 3'd5,
		OP_MID     = 3'd6,
		OP_QUERY   = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_BAD_SLOT = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_START,
		S_INS_CMP,
		S_CL_CMP,
		S_DEL_MOVE,
		S_DEL_END,
		S_CLAMP,
		S_MID_A,
		S_MID_SUM,
		S_FIND_START,
		S_FIND_CMP,
		S_READOUT,
		S_RD_LOC,
		S_RD_RS,
		S_RD_RE,
		S_DONE
	} state_t;

	typedef enum logic {
		ALU_ABS,
		ALU_ADD
	} alu_mode_t;

	typedef struct packed {
		logic gt;
		logic eq;
		logic lt;
	} smt_alu_flags_t;

	typedef struct packed {
		op_t                     operation;
		logic [POS_W-1:0]        position;
		logic signed [IDX_W-1:0] index_value;
	} smt_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  selected_slot_out;
		logic [LEN_W-1:0]   selected_location;
		logic [COUNT_W-1:0] entry_count;
		logic [LEN_W-1:0]   range_start;
		logic [LEN_W-1:0]   range_end;
		status_t            status;
	} smt_result_t;

endpackage

`default_nettype wire

### design/smt_if.sv
// Valid/ready channel interfaces for the request and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface smt_in_if;
	logic                                valid;
	logic                                ready;
	logic [smt_pkg::OP_W-1:0]            operation;
	logic [smt_pkg::POS_W-1:0]           position;
	logic signed [smt_pkg::IDX_W-1:0]    index_value;

	modport source (output valid, output operation, output position, output index_value,
		input ready);
	modport sink (input valid, input operation, input position, input index_value,
		output ready);
endinterface

interface smt_out_if;
	logic                         valid;
	logic                         ready;
	logic [smt_pkg::SLOT_W-1:0]   selected_slot_out;
	logic [smt_pkg::LEN_W-1:0]    selected_location;
	logic [smt_pkg::COUNT_W-1:0]  entry_count;
	logic [smt_pkg::LEN_W-1:0]    range_start;
	logic [smt_pkg::LEN_W-1:0]    range_end;
	logic [smt_pkg::STATUS_W-1:0] status;

	modport source (output valid, output selected_slot_out, output selected_location,
		output entry_count, output range_start, output range_end, output status,
		input ready);
	modport sink (input valid, input selected_slot_out, input selected_location,
		input entry_count, input range_start, input range_end, input status,
		output ready);
endinterface

`default_nettype wire

### design/sorted_marker_table_core.sv
// Top level of the sorted marker table: config register, sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps an ascending table of frame positions with one selected
// slot. Each request beat on req (operation, position, index_value) gives exactly one
// result beat on rsp: selection, table size, a range and a status. The user must write
// the frame length register (cfg_we / cfg_wdata) only while idle; it is not enforced.
//
// One request is worked on at a time. req.ready is low from acceptance until
// the result is handed to the result register, and the result beat shows on
// rsp in the cycle that req.ready rises again. A sorted insert takes longer
// for each larger marker moved up, a delete for each marker moved down, and
// the nearest search for each marker. A midpoint insert also waits on the
// markers its insert moves and on the slots scanned for the new marker, never
// more than the count; the memory read port and the shared adder set these times.
//
// A stalled result beat does not block the next request; the sequencer waits
// only when a new result is ready while the previous one is still stalled.
// After reset the table is empty, slot 0 is selected and the frame length is
// all ones; the memory is not cleared, since entries at or above the count
// are never used.

module sorted_marker_table_core #(
	parameter int MAX_MARKERS   = smt_pkg::MAX_MARKERS_DEF,
	parameter int POSITION_BITS = smt_pkg::POSITION_BITS_DEF
) (
	input  var logic                      clk,
	input  var logic                      arst_n,
	input  var logic                      cfg_we,
	input  var logic [smt_pkg::LEN_W-1:0] cfg_wdata,
	smt_in_if.sink                        req,
	smt_out_if.source                     rsp
);

	// Frame length register; it bounds the range of the last slot.
	logic [smt_pkg::LEN_W-1:0] total_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_len_q <= smt_pkg::TOTAL_LEN_RST;
		end else if (cfg_we) begin
			total_len_q <= cfg_wdata;
		end
	end

	smt_pkg::smt_item_t   item;
	smt_pkg::smt_result_t eng_res;
	logic                 eng_ready;
	logic                 eng_res_valid;
	logic                 slot_free;

	always_comb begin
		item.operation   = smt_pkg::op_t'(req.operation);
		item.position    = req.position;
		item.index_value = req.index_value;
	end

	assign req.ready = eng_ready;

	smt_engine #(
		.MAX_MARKERS  (MAX_MARKERS),
		.POSITION_BITS(POSITION_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.total_len   (total_len_q),
		.item_valid  (req.valid),
		.item        (item),
		.item_ready  (eng_ready),
		.slot_free   (slot_free),
		.res_valid   (eng_res_valid),
		.res         (eng_res)
	);

	// Result register. The slot is free when it is empty or its beat is being
	// taken in this cycle, so a back-to-back handoff loses no cycle.
	logic                 rsp_valid_q;
	smt_pkg::smt_result_t rsp_q;

	assign slot_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eng_res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res_valid) begin
			rsp_q <= eng_res;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.selected_slot_out = rsp_q.selected_slot_out;
	assign rsp.selected_location = rsp_q.selected_location;
	assign rsp.entry_count       = rsp_q.entry_count;
	assign rsp.range_start       = rsp_q.range_start;
	assign rsp.range_end         = rsp_q.range_end;
	assign rsp.status            = rsp_q.status;

endmodule

`default_nettype wire

### design/smt_alu.sv
// Shared add / absolute-difference unit with compare flags.
`timescale 1ns / 1ps
`default_nettype none

module smt_alu #(
	parameter int W = smt_pkg::LEN_W
) (
	input  var smt_pkg::alu_mode_t      mode,
	input  var logic [W-1:0]            a,
	input  var logic [W-1:0]            b,
	input  var logic [W-1:0]            c,
	output var logic [W:0]              res,
	output var smt_pkg::smt_alu_flags_t flags
);

	logic          sub;
	logic [W-1:0]  b_x;
	logic [W:0]    sum;
	logic [W-1:0]  diff;
	logic [W-1:0]  abs_diff;

	always_comb begin
		sub      = (mode == smt_pkg::ALU_ABS);
		b_x      = sub ? ~b : b;
		sum      = {1'b0, a} + {1'b0, b_x} + {{W{1'b0}}, sub};
		diff     = sum[W-1:0];
		// In subtract mode the carry out is set when a >= b.
		abs_diff = sum[W] ? diff : (~diff + {{(W-1){1'b0}}, 1'b1});
		res      = sub ? {1'b0, abs_diff} : sum;
		flags.eq = (diff == '0);
		flags.gt = sum[W] && (diff != '0);
		flags.lt = (res[W-1:0] < c);
	end

endmodule

`default_nettype wire

### design/smt_engine.sv
// Sequencer and marker memory that carry out one table operation at a time.
`timescale 1ns / 1ps
`default_nettype none

module smt_engine #(
	parameter int MAX_MARKERS   = smt_pkg::MAX_MARKERS_DEF,
	parameter int POSITION_BITS = smt_pkg::POSITION_BITS_DEF
) (
	input  var logic                        clk,
	input  var logic                        arst_n,
	input  var logic [smt_pkg::LEN_W-1:0]   total_len,
	input  var logic                        item_valid,
	input  var smt_pkg::smt_item_t          item,
	output var logic                        item_ready,
	input  var logic                        slot_free,
	output var logic                        res_valid,
	output var smt_pkg::smt_result_t        res
);

	localparam int SW  = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
	localparam int CW  = $clog2(MAX_MARKERS + 1);
	localparam int PB  = POSITION_BITS;
	localparam int LW  = smt_pkg::LEN_W;
	localparam int WB  = (PB > LW) ? PB : LW;
	localparam int IW  = smt_pkg::IDX_W;
	localparam int WW  = ((CW > IW) ? CW : IW) + 2;
	localparam int SLW = smt_pkg::SLOT_W;
	localparam int CNW = smt_pkg::COUNT_W;

	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_MARKERS);

	// Marker memory: one write and one registered read per cycle.
	logic [PB-1:0] mem_q [MAX_MARKERS];
	logic [PB-1:0] rd_q;
	logic          we;
	logic [SW-1:0] waddr;
	logic [PB-1:0] wdata;
	logic [SW-1:0] raddr;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	smt_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [SW-1:0]    sel_q, sel_d;
	smt_pkg::op_t     op_q, op_d;
	logic [PB-1:0]    pos_q, pos_d;
	logic signed [IW-1:0] idx_q, idx_d;
	logic [CW-1:0]    i_q, i_d;
	logic [PB-1:0]    val_q, val_d;
	logic [PB-1:0]    best_q, best_d;
	logic signed [WW-1:0] want_q, want_d;
	smt_pkg::status_t status_q, status_d;
	logic             use_fl_q, use_fl_d;
	logic [SW-1:0]    rslot_q, rslot_d;
	logic             rvalid_q, rvalid_d;
	logic [LW-1:0]    loc_q, loc_d;
	logic [LW-1:0]    rs_q, rs_d;
	logic [LW-1:0]    re_q, re_d;

	smt_pkg::alu_mode_t      alu_mode;
	logic [WB-1:0]           alu_a, alu_b, alu_c;
	logic [WB:0]             alu_res;
	smt_pkg::smt_alu_flags_t alu_flags;

	smt_alu #(
		.W(WB)
	) u_alu (
		.mode (alu_mode),
		.a    (alu_a),
		.b    (alu_b),
		.c    (alu_c),
		.res  (alu_res),
		.flags(alu_flags)
	);

	logic signed [WW-1:0] idx_ext, sel_ext, cnt_ext;
	logic [CW:0]          cnt_w, sel_p1, i_p1, i_p2, r_p1;
	logic                 bad_slot;
	logic [SW-1:0]        clamp_sel;

	always_comb begin
		idx_ext  = $signed({{(WW-IW){idx_q[IW-1]}}, idx_q});
		sel_ext  = $signed({{(WW-SW){1'b0}}, sel_q});
		cnt_ext  = $signed({{(WW-CW){1'b0}}, cnt_q});
		cnt_w    = {1'b0, cnt_q};
		sel_p1   = (CW+1)'(sel_q) + (CW+1)'(1);
		i_p1     = {1'b0, i_q} + (CW+1)'(1);
		i_p2     = {1'b0, i_q} + (CW+1)'(2);
		r_p1     = (CW+1)'(rslot_q) + (CW+1)'(1);
		bad_slot = idx_q[IW-1] || (idx_ext >= cnt_ext);
		if ((cnt_q == '0) || want_q[WW-1]) begin
			clamp_sel = '0;
		end else if (want_q >= cnt_ext) begin
			clamp_sel = SW'(cnt_q - CW'(1));
		end else begin
			clamp_sel = want_q[SW-1:0];
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		sel_d     = sel_q;
		op_d      = op_q;
		pos_d     = pos_q;
		idx_d     = idx_q;
		i_d       = i_q;
		val_d     = val_q;
		best_d    = best_q;
		want_d    = want_q;
		status_d  = status_q;
		use_fl_d  = use_fl_q;
		rslot_d   = rslot_q;
		rvalid_d  = rvalid_q;
		loc_d     = loc_q;
		rs_d      = rs_q;
		re_d      = re_q;
		we        = 1'b0;
		waddr     = i_q[SW-1:0];
		wdata     = val_q;
		raddr     = '0;
		alu_mode  = smt_pkg::ALU_ABS;
		alu_a     = WB'(rd_q);
		alu_b     = WB'(val_q);
		alu_c     = WB'(best_q);
		item_ready = 1'b0;
		res_valid  = 1'b0;

		unique case (state_q)
			smt_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					op_d     = item.operation;
					pos_d    = PB'(item.position);
					idx_d    = item.index_value;
					status_d = smt_pkg::STAT_OK;
					state_d  = smt_pkg::S_DISPATCH;
				end
			end

			smt_pkg::S_DISPATCH: begin
				unique case (op_q)
					smt_pkg::OP_CLEAR: begin
						cnt_d   = '0;
						sel_d   = '0;
						state_d = smt_pkg::S_READOUT;
					end
					smt_pkg::OP_ADD: begin
						if (cnt_q == FULL_COUNT) begin
							status_d = smt_pkg::STAT_FULL;
							state_d  = smt_pkg::S_READOUT;
						end else begin
							val_d   = pos_q;
							i_d     = cnt_q;
							state_d = smt_pkg::S_INS_START;
						end
					end
					smt_pkg::OP_SET: begin
						want_d  = idx_ext;
						state_d = smt_pkg::S_CLAMP;
					end
					smt_pkg::OP_SHIFT: begin
						want_d  = sel_ext + idx_ext;
						state_d = smt_pkg::S_CLAMP;
					end
					smt_pkg::OP_CLOSEST: begin
						if (cnt_q == '0) begin
							status_d = smt_pkg::STAT_EMPTY;
							state_d  = smt_pkg::S_READOUT;
						end else begin
							raddr   = '0;
							i_d     = '0;
							state_d = smt_pkg::S_CL_CMP;
						end
					end
					smt_pkg::OP_DELETE: begin
						if (cnt_q == '0) begin
							status_d = smt_pkg::STAT_EMPTY;
							state_d  = smt_pkg::S_READOUT;
						end else begin
							i_d = CW'(sel_q);
							if (sel_p1 < cnt_w) begin
								raddr   = SW'(sel_p1);
								state_d = smt_pkg::S_DEL_MOVE;
							end else begin
								state_d = smt_pkg::S_DEL_END;
							end
						end
					end
					smt_pkg::OP_MID: begin
						if (cnt_q == '0) begin
							we      = 1'b1;
							waddr   = '0;
							wdata   = '0;
							cnt_d   = CW'(1);
							sel_d   = '0;
							state_d = smt_pkg::S_READOUT;
						end else if (cnt_q == FULL_COUNT) begin
							status_d = smt_pkg::STAT_FULL;
							state_d  = smt_pkg::S_READOUT;
						end else begin
							raddr   = sel_q;
							state_d = smt_pkg::S_MID_A;
						end
					end
					smt_pkg::OP_QUERY: begin
						state_d = smt_pkg::S_READOUT;
					end
					default: begin
						state_d = smt_pkg::S_READOUT;
					end
				endcase
			end

			// Sorted insert: walk down from the top, moving larger entries up one slot.
			smt_pkg::S_INS_START: begin
				if (i_q == '0) begin
					we      = 1'b1;
					waddr   = '0;
					wdata   = val_q;
					cnt_d   = cnt_q + CW'(1);
					state_d = (op_q == smt_pkg::OP_MID) ? smt_pkg::S_FIND_START
						: smt_pkg::S_READOUT;
				end else begin
					raddr   = SW'(i_q - CW'(1));
					state_d = smt_pkg::S_INS_CMP;
				end
			end

			smt_pkg::S_INS_CMP: begin
				we = 1'b1;
				if (alu_flags.gt) begin
					waddr = SW'(i_q);
					wdata = rd_q;
					i_d   = i_q - CW'(1);
					if (i_q >= CW'(2)) begin
						raddr = SW'(i_q - CW'(2));
					end else begin
						state_d = smt_pkg::S_INS_START;
					end
				end else begin
					waddr   = SW'(i_q);
					wdata   = val_q;
					cnt_d   = cnt_q + CW'(1);
					state_d = (op_q == smt_pkg::OP_MID) ? smt_pkg::S_FIND_START
						: smt_pkg::S_READOUT;
				end
			end

			// Nearest search: one stored marker per cycle, strict improvement only.
			smt_pkg::S_CL_CMP: begin
				alu_b = WB'(pos_q);
				if ((i_q == '0) || alu_flags.lt) begin
					best_d = alu_res[PB-1:0];
					sel_d  = SW'(i_q);
				end
				if (i_p1 < cnt_w) begin
					raddr = SW'(i_p1);
					i_d   = CW'(i_p1);
				end else begin
					state_d = smt_pkg::S_READOUT;
				end
			end

			smt_pkg::S_DEL_MOVE: begin
				we    = 1'b1;
				waddr = SW'(i_q);
				wdata = rd_q;
				i_d   = CW'(i_p1);
				if (i_p2 < cnt_w) begin
					raddr = SW'(i_p2);
				end else begin
					state_d = smt_pkg::S_DEL_END;
				end
			end

			smt_pkg::S_DEL_END: begin
				cnt_d   = cnt_q - CW'(1);
				want_d  = sel_ext;
				state_d = smt_pkg::S_CLAMP;
			end

			smt_pkg::S_CLAMP: begin
				sel_d   = clamp_sel;
				state_d = smt_pkg::S_READOUT;
			end

			smt_pkg::S_MID_A: begin
				val_d    = rd_q;
				use_fl_d = !(sel_p1 < cnt_w);
				if (sel_p1 < cnt_w) begin
					raddr = SW'(sel_p1);
				end
				state_d = smt_pkg::S_MID_SUM;
			end

			smt_pkg::S_MID_SUM: begin
				alu_mode = smt_pkg::ALU_ADD;
				alu_a    = WB'(val_q);
				alu_b    = use_fl_q ? WB'(total_len) : WB'(rd_q);
				val_d    = alu_res[PB:1];
				i_d      = cnt_q;
				state_d  = smt_pkg::S_INS_START;
			end

			smt_pkg::S_FIND_START: begin
				raddr   = '0;
				i_d     = '0;
				state_d = smt_pkg::S_FIND_CMP;
			end

			// The new marker is always present, so the scan ends inside the table.
			smt_pkg::S_FIND_CMP: begin
				if (alu_flags.eq) begin
					sel_d   = SW'(i_q);
					state_d = smt_pkg::S_READOUT;
				end else begin
					raddr = SW'(i_p1);
					i_d   = CW'(i_p1);
				end
			end

			smt_pkg::S_READOUT: begin
				raddr = sel_q;
				if (op_q == smt_pkg::OP_QUERY) begin
					rslot_d  = idx_ext[SW-1:0];
					rvalid_d = !bad_slot;
					if (bad_slot) begin
						status_d = smt_pkg::STAT_BAD_SLOT;
					end
				end else begin
					rslot_d  = sel_q;
					rvalid_d = (cnt_q != '0);
				end
				state_d = smt_pkg::S_RD_LOC;
			end

			smt_pkg::S_RD_LOC: begin
				loc_d   = (cnt_q != '0) ? LW'(rd_q) : '0;
				raddr   = rslot_q;
				state_d = smt_pkg::S_RD_RS;
			end

			smt_pkg::S_RD_RS: begin
				rs_d    = rvalid_q ? LW'(rd_q) : '0;
				raddr   = SW'(r_p1);
				state_d = smt_pkg::S_RD_RE;
			end

			smt_pkg::S_RD_RE: begin
				if (!rvalid_q) begin
					re_d = '0;
				end else if (r_p1 < cnt_w) begin
					re_d = LW'(rd_q);
				end else begin
					re_d = total_len;
				end
				state_d = smt_pkg::S_DONE;
			end

			smt_pkg::S_DONE: begin
				if (slot_free) begin
					res_valid = 1'b1;
					state_d   = smt_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = smt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smt_pkg::S_IDLE;
			cnt_q   <= '0;
			sel_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		pos_q    <= pos_d;
		idx_q    <= idx_d;
		i_q      <= i_d;
		val_q    <= val_d;
		best_q   <= best_d;
		want_q   <= want_d;
		status_q <= status_d;
		use_fl_q <= use_fl_d;
		rslot_q  <= rslot_d;
		rvalid_q <= rvalid_d;
		loc_q    <= loc_d;
		rs_q     <= rs_d;
		re_q     <= re_d;
	end

	always_comb begin
		res.selected_slot_out = SLW'(sel_q);
		res.selected_location = loc_q;
		res.entry_count       = CNW'(cnt_q);
		res.range_start       = rs_q;
		res.range_end         = re_q;
		res.status            = status_q;
	end

endmodule

`default_nettype wire
